FILE: hw/rtl/qalu_pkg.sv
// Package for the quaternion arithmetic unit.
// Holds the operation codes and the control record that travels down the pipeline.
// Has no dependencies.
package qalu_pkg;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_CONJ = 3'd3,
        OP_NORM = 3'd4,
        OP_INV  = 3'd5
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_ctrl;

endpackage

FILE: hw/rtl/qalu_iter.sv
// One registered step of the shared divide and square root chain.
// Resolves quotient bit K of four restoring dividers and root bit K of one square root.
// No package dependencies.
module qalu_iter #(
    parameter int W  = 32,
    parameter int K  = 0,
    parameter int NW = 64,
    parameter int SW = 65,
    parameter int DW = 98
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [SW-1:0]        i_s,
    input  logic [3:0][NW-1:0]   i_rem,
    input  logic [3:0][W:0]      i_q,
    input  logic [SW-1:0]        i_sq_rem,
    input  logic [W:0]           i_root,
    output logic [SW-1:0]        o_s,
    output logic [3:0][NW-1:0]   o_rem,
    output logic [3:0][W:0]      o_q,
    output logic [SW-1:0]        o_sq_rem,
    output logic [W:0]           o_root
);

    logic [DW-1:0]          trial;
    logic [3:0]             ge;
    logic [3:0][NW-1:0]     n_rem;
    logic [3:0][W:0]        n_q;
    logic [SW:0]            sq_trial;
    logic                   sq_ge;
    logic [SW-1:0]          n_sq_rem;
    logic [W:0]             n_root;

    logic [SW-1:0]          r_s;
    logic [3:0][NW-1:0]     r_rem;
    logic [3:0][W:0]        r_q;
    logic [SW-1:0]          r_sq_rem;
    logic [W:0]             r_root;

    always_comb begin
        trial = DW'(i_s) << K;
        for (int i = 0; i < 4; i++) begin
            ge[i]    = DW'(i_rem[i]) >= trial;
            n_rem[i] = ge[i] ? NW'(DW'(i_rem[i]) - trial) : i_rem[i];
            n_q[i]   = i_q[i];
            n_q[i][K] = ge[i];
        end
        sq_trial = ((SW+1)'(i_root) << (K + 1)) | ((SW+1)'(1) << (2 * K));
        sq_ge    = (SW+1)'(i_sq_rem) >= sq_trial;
        n_sq_rem = sq_ge ? SW'((SW+1)'(i_sq_rem) - sq_trial) : i_sq_rem;
        n_root   = i_root;
        n_root[K] = sq_ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s      <= i_s;
            r_rem    <= n_rem;
            r_q      <= n_q;
            r_sq_rem <= n_sq_rem;
            r_root   <= n_root;
        end
    end

    assign o_s      = r_s;
    assign o_rem    = r_rem;
    assign o_q      = r_q;
    assign o_sq_rem = r_sq_rem;
    assign o_root   = r_root;

endmodule

FILE: hw/rtl/quaternion_alu.sv
// Top level of the pipelined quaternion arithmetic unit.
// Depends on qalu_pkg and qalu_iter.
//
// Usage: the slave channel carries one operation per transfer. tuser holds the
// operation code, tdata holds a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, each WIDTH
// bits in signed fixed point with FRAC_BITS fraction bits. The master channel
// returns one transfer per input: tdata holds r_w, r_x, r_y, r_z and tuser holds
// the saturated and zero_divide flags.
// Every operation passes the same registers: four front stages for operand
// capture, the sixteen multipliers, the sums and the multiply saturation, then
// WIDTH + 1 stages of the bit-per-stage divide and square root chain, then the
// output register. The chain length is set by the quotient and root width. One
// transfer is accepted every cycle unless the master side stalls.
// A stall on the master side freezes the whole pipeline; items already in
// flight are held, none is lost or repeated. Reset clears all valid bits; the
// block has no other state and needs no clearing pass.
module quaternion_alu
    import qalu_pkg::*;
#(
    parameter int WIDTH     = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from the lowest bit up.
    input  logic [8*WIDTH-1:0]                   i_s_axis_tdata,
    // operation.
    input  logic [2:0]                           i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // r_w, r_x, r_y, r_z from the lowest bit up, zero filled to whole bytes.
    output logic [((4*WIDTH+7)/8)*8-1:0]         o_m_axis_tdata,
    // saturated, zero_divide from the lowest bit up.
    output logic [1:0]                           o_m_axis_tuser
);

    localparam int W   = WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2*W + 2;
    localparam int SW  = 2*W + 1;
    localparam int NW  = W + 2*F;
    localparam int DW  = ((NW > SW + W) ? NW : SW + W) + 1;
    localparam int NIT = W + 1;
    localparam int TDO = ((4*W+7)/8)*8;

    logic en;

    logic                 r_v0;
    t_op                  r_op0;
    logic signed [W-1:0]  r_a0 [4];
    logic signed [W-1:0]  r_b0 [4];
    t_op                  in_op;

    logic                  r_v1;
    t_op                   r_op1;
    logic signed [2*W-1:0] r_p1 [4][4];
    logic [3:0][W-1:0]     r_side1;
    logic                  r_sat1;
    logic [3:0][W-1:0]     r_mag1;
    logic [3:0]            r_neg1;
    logic [3:0][W-1:0]     n_side1;
    logic                  n_sat1;
    logic [3:0][W-1:0]     n_mag1;
    logic [3:0]            n_neg1;

    logic                  r_v2;
    t_op                   r_op2;
    logic signed [PW-1:0]  r_c2 [4];
    logic [SW-1:0]         r_s2;
    logic [3:0][W-1:0]     r_side2;
    logic                  r_sat2;
    logic [3:0][W-1:0]     r_mag2;
    logic [3:0]            r_neg2;

    logic                  r_v3;
    t_op                   r_op3;
    logic [3:0][W-1:0]     r_side3;
    logic                  r_sat3;
    logic [3:0]            r_neg3;
    logic [3:0]            r_ovf3;
    logic                  r_zero3;
    logic [3:0][NW-1:0]    r_rem3;
    logic [SW-1:0]         r_s3;
    logic [3:0][W-1:0]     n_side3;
    logic                  n_sat3;
    logic [3:0]            n_ovf3;
    logic [3:0][NW-1:0]    n_rem3;

    logic [SW-1:0]         w_s    [NIT+1];
    logic [3:0][NW-1:0]    w_rem  [NIT+1];
    logic [3:0][W:0]       w_q    [NIT+1];
    logic [SW-1:0]         w_sqr  [NIT+1];
    logic [W:0]            w_root [NIT+1];

    t_ctrl                 r_ci    [NIT];
    logic [3:0][W-1:0]     r_sidei [NIT];
    logic                  r_sati  [NIT];
    logic [3:0]            r_negi  [NIT];
    logic [3:0]            r_ovfi  [NIT];
    logic                  r_zeroi [NIT];

    logic                  r_out_v;
    t_op                   r_out_op;
    logic [3:0][W-1:0]     r_out_q;
    logic                  r_out_sat;
    logic                  r_out_zdiv;
    logic [3:0][W-1:0]     n_out_q;
    logic                  n_out_sat;
    logic                  n_out_zdiv;

    function automatic logic [W:0] sat_narrow(logic [W:0] x);
        logic [W-1:0] v;
        logic         f;
        f = x[W] != x[W-1];
        v = f ? (x[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) : x[W-1:0];
        return {f, v};
    endfunction

    function automatic logic signed [PW-1:0] sx(logic signed [2*W-1:0] p);
        return PW'(p);
    endfunction

    assign en              = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign in_op           = t_op'(i_s_axis_tuser);

    // Stage 0: capture operands; norm and inverse square a against itself.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_s_axis_tvalid;
        end
        if (en) begin
            r_op0 <= in_op;
            for (int i = 0; i < 4; i++) begin
                r_a0[i] <= i_s_axis_tdata[i*W +: W];
                r_b0[i] <= (in_op == OP_NORM || in_op == OP_INV) ?
                           i_s_axis_tdata[i*W +: W] : i_s_axis_tdata[(4+i)*W +: W];
            end
        end
    end

    // Stage 1: sixteen products, add, subtract and conjugate, and the magnitudes and signs for the inverse.
    always_comb begin
        logic [W:0] t;
        n_side1 = '0;
        n_sat1  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            case (r_op0)
                OP_ADD:  t = sat_narrow({r_a0[i][W-1], r_a0[i]} + {r_b0[i][W-1], r_b0[i]});
                OP_SUB:  t = sat_narrow({r_a0[i][W-1], r_a0[i]} - {r_b0[i][W-1], r_b0[i]});
                OP_CONJ: t = (i == 0) ? {1'b0, r_a0[i]} :
                             sat_narrow((W+1)'(0) - {r_a0[i][W-1], r_a0[i]});
                default: t = '0;
            endcase
            n_side1[i] = t[W-1:0];
            n_sat1     = n_sat1 | t[W];
            n_neg1[i]  = (i == 0) ? r_a0[i] < 0 : r_a0[i] > 0;
            n_mag1[i]  = (r_a0[i] < 0) ? W'(-r_a0[i]) : W'(r_a0[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
        end
        if (en) begin
            r_op1   <= r_op0;
            r_side1 <= n_side1;
            r_sat1  <= n_sat1;
            r_mag1  <= n_mag1;
            r_neg1  <= n_neg1;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_p1[i][j] <= r_a0[i] * r_b0[j];
                end
            end
        end
    end

    // Stage 2: Hamilton sums and the squared norm.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            r_op2   <= r_op1;
            r_side2 <= r_side1;
            r_sat2  <= r_sat1;
            r_mag2  <= r_mag1;
            r_neg2  <= r_neg1;
            r_c2[0] <= sx(r_p1[0][0]) - sx(r_p1[1][1]) - sx(r_p1[2][2]) - sx(r_p1[3][3]);
            r_c2[1] <= sx(r_p1[0][1]) + sx(r_p1[1][0]) + sx(r_p1[2][3]) - sx(r_p1[3][2]);
            r_c2[2] <= sx(r_p1[0][2]) - sx(r_p1[1][3]) + sx(r_p1[2][0]) + sx(r_p1[3][1]);
            r_c2[3] <= sx(r_p1[0][3]) + sx(r_p1[1][2]) - sx(r_p1[2][1]) + sx(r_p1[3][0]);
            r_s2    <= SW'(r_p1[0][0]) + SW'(r_p1[1][1]) + SW'(r_p1[2][2]) + SW'(r_p1[3][3]);
        end
    end

    // Stage 3: scale and saturate the product, set up the divide chain.
    always_comb begin
        logic signed [PW-1:0] t;
        logic                 fits;
        n_side3 = r_side2;
        n_sat3  = r_sat2;
        for (int i = 0; i < 4; i++) begin
            t    = r_c2[i] >>> F;
            fits = (&t[PW-1:W-1]) || !(|t[PW-1:W-1]);
            if (r_op2 == OP_MUL) begin
                n_side3[i] = fits ? t[W-1:0] :
                             (t[PW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
                n_sat3     = n_sat3 | !fits;
            end
            n_rem3[i] = NW'(r_mag2[i]) << (2*F);
            n_ovf3[i] = DW'(n_rem3[i]) >= (DW'(r_s2) << W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
        if (en) begin
            r_op3   <= r_op2;
            r_side3 <= n_side3;
            r_sat3  <= n_sat3;
            r_neg3  <= r_neg2;
            r_ovf3  <= n_ovf3;
            r_zero3 <= r_s2 == '0;
            r_rem3  <= n_rem3;
            r_s3    <= r_s2;
        end
    end

    assign w_s[0]    = r_s3;
    assign w_rem[0]  = r_rem3;
    assign w_q[0]    = '0;
    assign w_sqr[0]  = r_s3;
    assign w_root[0] = '0;

    for (genvar j = 0; j < NIT; j++) begin : g_iter
        qalu_iter #(
            .W  (W),
            .K  (W - j),
            .NW (NW),
            .SW (SW),
            .DW (DW)
        ) u_iter (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_s      (w_s[j]),
            .i_rem    (w_rem[j]),
            .i_q      (w_q[j]),
            .i_sq_rem (w_sqr[j]),
            .i_root   (w_root[j]),
            .o_s      (w_s[j+1]),
            .o_rem    (w_rem[j+1]),
            .o_q      (w_q[j+1]),
            .o_sq_rem (w_sqr[j+1]),
            .o_root   (w_root[j+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NIT; j++) begin
                r_ci[j].valid <= 1'b0;
            end
        end else if (en) begin
            r_ci[0].valid <= r_v3;
            for (int j = 1; j < NIT; j++) begin
                r_ci[j].valid <= r_ci[j-1].valid;
            end
        end
        if (en) begin
            r_ci[0].op  <= r_op3;
            r_sidei[0]  <= r_side3;
            r_sati[0]   <= r_sat3;
            r_negi[0]   <= r_neg3;
            r_ovfi[0]   <= r_ovf3;
            r_zeroi[0]  <= r_zero3;
            for (int j = 1; j < NIT; j++) begin
                r_ci[j].op <= r_ci[j-1].op;
                r_sidei[j] <= r_sidei[j-1];
                r_sati[j]  <= r_sati[j-1];
                r_negi[j]  <= r_negi[j-1];
                r_ovfi[j]  <= r_ovfi[j-1];
                r_zeroi[j] <= r_zeroi[j-1];
            end
        end
    end

    // Final selection of the result: norm and inverse from the chain, all other operations from the side path.
    always_comb begin
        logic [W:0] q;
        logic       clamp;
        n_out_q    = r_sidei[NIT-1];
        n_out_sat  = r_sati[NIT-1];
        n_out_zdiv = 1'b0;
        case (r_ci[NIT-1].op)
            OP_NORM: begin
                n_out_q = '0;
                if (w_root[NIT][W:W-1] != 2'b00) begin
                    n_out_q[0] = {1'b0, {(W-1){1'b1}}};
                    n_out_sat  = 1'b1;
                end else begin
                    n_out_q[0] = w_root[NIT][W-1:0];
                end
            end
            OP_INV: begin
                n_out_q = '0;
                if (r_zeroi[NIT-1]) begin
                    n_out_zdiv = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        q = w_q[NIT][i];
                        if (r_negi[NIT-1][i]) begin
                            clamp = r_ovfi[NIT-1][i] || q[W] || (q[W-1] && (|q[W-2:0]));
                            n_out_q[i] = clamp ? {1'b1, {(W-1){1'b0}}} :
                                         W'((W+1)'(0) - q);
                        end else begin
                            clamp = r_ovfi[NIT-1][i] || (q[W:W-1] != 2'b00);
                            n_out_q[i] = clamp ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
                        end
                        n_out_sat = n_out_sat | clamp;
                    end
                end
            end
            default: begin
                n_out_q = r_sidei[NIT-1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_ci[NIT-1].valid;
        end
        if (en) begin
            r_out_op   <= r_ci[NIT-1].op;
            r_out_q    <= n_out_q;
            r_out_sat  <= n_out_sat;
            r_out_zdiv <= n_out_zdiv;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = TDO'(r_out_q);
    assign o_m_axis_tuser  = {r_out_zdiv, r_out_sat};

    a_zdiv_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_zdiv |-> r_out_q == '0 && !r_out_sat)
        else $error("zero divide result is not clean");

    a_zdiv_only_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_zdiv |-> r_out_op == OP_INV)
        else $error("zero divide raised outside inverse");

    a_norm_vector_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_op == OP_NORM |-> r_out_q[1] == '0 && r_out_q[2] == '0
            && r_out_q[3] == '0)
        else $error("norm result has a vector part");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !i_m_axis_tready |=> $stable(r_ci[NIT-1].valid) && $stable(r_v3))
        else $error("pipeline moved during a stall");

endmodule

FILE: tb/quaternion_alu_checker.sv
// Checker for the quaternion arithmetic unit: watches both stream channels,
// predicts each result from the accepted input transfer and compares it.
// Depends on qalu_pkg.
module quaternion_alu_checker
    import qalu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [255:0] i_s_data,
    input  logic [2:0]   i_s_user,
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [127:0] i_m_data,
    input  logic [1:0]   i_m_user,
    output int           o_fail_count,
    output int           o_pending
);
    typedef struct packed {
        logic [1:0]   flags;
        logic [127:0] comps;
    } t_quat_result;

    t_quat_result pending_results[$];

    string comp_names[4] = '{"r_w", "r_x", "r_y", "r_z"};

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] x,
                                                 inout logic flag);
        if (x > 128'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7fffffff;
        end
        if (x < -128'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic [127:0] isqrt(input logic [127:0] n);
        logic [127:0] res;
        logic [127:0] bitv;
        res = 0;
        bitv = 128'd1 << 126;
        while (bitv != 0 && n < bitv) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_quat_result compute_quat(input logic [2:0] op,
                                                  input logic [255:0] d);
        logic signed [127:0] a [4];
        logic signed [127:0] b [4];
        logic signed [127:0] c [4];
        logic signed [127:0] s;
        logic signed [127:0] cv;
        logic [127:0] q;
        logic [31:0] r [4];
        logic satf;
        logic zdiv;
        t_quat_result res;
        satf = 0;
        zdiv = 0;
        for (int i = 0; i < 4; i++) begin
            a[i] = $signed(d[32*i +: 32]);
            b[i] = $signed(d[128 + 32*i +: 32]);
            r[i] = 0;
        end
        s = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
        case (op)
            OP_ADD, OP_SUB: begin
                for (int i = 0; i < 4; i++)
                    r[i] = clamp32(op == OP_ADD ? a[i] + b[i] : a[i] - b[i], satf);
            end
            OP_MUL: begin
                c[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
                c[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
                c[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
                c[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
                for (int i = 0; i < 4; i++) r[i] = clamp32(c[i] >>> 16, satf);
            end
            OP_CONJ: begin
                r[0] = clamp32(a[0], satf);
                for (int i = 1; i < 4; i++) r[i] = clamp32(-a[i], satf);
            end
            OP_NORM: begin
                r[0] = clamp32($signed(isqrt(s)), satf);
            end
            OP_INV: begin
                if (s == 0) begin
                    zdiv = 1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        cv = (i == 0) ? a[0] : -a[i];
                        q = ((cv < 0 ? -cv : cv) << 32) / s;
                        r[i] = clamp32(cv < 0 ? -$signed(q) : $signed(q), satf);
                    end
                end
            end
            default: ;
        endcase
        res.comps = {r[3], r[2], r[1], r[0]};
        res.flags = {zdiv, satf};
        return res;
    endfunction

    assign o_pending = pending_results.size();

    always @(posedge i_clk) begin
        t_quat_result exp_r;
        int n_err;
        n_err = 0;
        if (i_rst_n && i_s_valid && i_s_ready)
            pending_results.push_back(compute_quat(i_s_user, i_s_data));
        if (i_rst_n && i_m_valid && i_m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer");
                n_err++;
            end else begin
                exp_r = pending_results.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (exp_r.comps[32*i +: 32] !== i_m_data[32*i +: 32]) begin
                        $error("%s: expected %h, actual %h", comp_names[i],
                               exp_r.comps[32*i +: 32], i_m_data[32*i +: 32]);
                        n_err++;
                    end
                end
                if (exp_r.flags[0] !== i_m_user[0]) begin
                    $error("saturated: expected %b, actual %b", exp_r.flags[0], i_m_user[0]);
                    n_err++;
                end
                if (exp_r.flags[1] !== i_m_user[1]) begin
                    $error("zero_divide: expected %b, actual %b",
                           exp_r.flags[1], i_m_user[1]);
                    n_err++;
                end
            end
        end
        if (n_err != 0) o_fail_count <= o_fail_count + n_err;
    end
endmodule

FILE: tb/tb_quaternion_alu.sv
// Testbench top for the quaternion arithmetic unit: drives directed and random
// operations with random idling on both sides and gives the verdict.
// Depends on qalu_pkg, quaternion_alu and quaternion_alu_checker.
module tb_quaternion_alu;
    import qalu_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 5000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_valid = 0;
    logic         s_ready;
    logic [255:0] s_data = 0;
    logic [2:0]   s_user = 0;
    logic         m_valid;
    logic         m_ready = 0;
    logic [127:0] m_data;
    logic [1:0]   m_user;
    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    bit           calm = 0;

    always #1 i_clk = ~i_clk;

    quaternion_alu dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user)
    );

    quaternion_alu_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data), .i_s_user(s_user),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data), .i_m_user(m_user),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        m_ready <= calm || ($urandom_range(99) >= 6);
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h0;
            3: return $urandom_range(131071) - 65536;
            4: return $urandom_range(1) ? 32'h00010000 : 32'hffff0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_quat(input logic [2:0] op, input logic [255:0] d);
        while (!calm && $urandom_range(99) < 6) begin
            s_valid <= 0;
            @(posedge i_clk);
        end
        s_valid <= 1;
        s_user <= op;
        s_data <= d;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    task automatic send_uniform(input logic [2:0] op, input logic [31:0] v);
        send_quat(op, {8{v}});
    endtask

    initial begin
        logic [255:0] d;
        int waited;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        for (int op = 0; op < 8; op++) begin
            send_uniform(3'(op), 32'h7fffffff);
            send_uniform(3'(op), 32'h80000000);
        end
        send_uniform(OP_INV, 32'h0);
        send_uniform(OP_NORM, 32'h0);
        send_quat(OP_INV, {224'h0, 32'h00010000});
        send_quat(OP_INV, {192'h0, 32'h00000001, 32'h0});
        send_quat(OP_CONJ, {128'h0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h1});
        send_quat(OP_MUL, {32'h0, 32'h0, 32'h00010000, 32'h0,
                           32'h0, 32'h0, 32'h0, 32'h00010000});
        send_uniform(OP_MUL, 32'hffffffff);
        for (int n = 0; n < 1850; n++) begin
            calm = (n >= 600 && n < 900);
            if (n == 1200) begin
                s_valid <= 0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            for (int i = 0; i < 8; i++) d[32*i +: 32] = rand_comp();
            if ($urandom_range(15) == 0) d[127:0] = 0;
            send_quat($urandom_range(15) == 0 ? 3'($urandom_range(7, 6))
                                              : 3'($urandom_range(5)), d);
        end
        calm = 0;
        s_valid <= 0;
        @(posedge i_clk);
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
